// ===== src/rrb_pkg.sv =====
package rrb_pkg;

    localparam int ROW_DEPTH_DEF = 16;
    localparam int ROW_WIDTH_DEF = 4;

    localparam logic [2:0] REQ_WRITE     = 3'd0;
    localparam logic [2:0] REQ_COMMIT    = 3'd1;
    localparam logic [2:0] REQ_REL_FIRST = 3'd2;
    localparam logic [2:0] REQ_REL_LAST  = 3'd3;
    localparam logic [2:0] REQ_RD_FIRST  = 3'd4;
    localparam logic [2:0] REQ_RD_LAST   = 3'd5;
    localparam logic [2:0] REQ_RD_AT     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         lane;
        logic [3:0]         position;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         stored_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic advance;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
    } dp_stat_t;

endpackage

// ===== src/rrb_ctrl.sv =====
module rrb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  rrb_pkg::dp_stat_t stat,
    output rrb_pkg::dp_cmd_t  cmd
);
    import rrb_pkg::*;

    localparam logic S_CLEAR = 1'b0;
    localparam logic S_RUN   = 1'b1;

    logic state_reg;
    logic state_next;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic run;

    assign run       = (state_reg == S_RUN);
    assign req_stall = !run || (s1_valid_reg && rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.clear_step = !run;
        cmd.accept     = run && req_valid && !req_stall;
        cmd.advance    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);

        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        s1_valid_next = s1_valid_reg;
        if (cmd.accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (cmd.advance)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== src/rrb_datapath.sv =====
module rrb_datapath #(
    parameter int ROW_DEPTH = rrb_pkg::ROW_DEPTH_DEF,
    parameter int ROW_WIDTH = rrb_pkg::ROW_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rrb_pkg::dp_cmd_t  cmd,
    output rrb_pkg::dp_stat_t stat,
    input  rrb_pkg::req_t     req_data,
    output rrb_pkg::rsp_t     rsp_data
);
    import rrb_pkg::*;

    localparam int RAW       = $clog2(ROW_DEPTH);
    localparam int CW        = $clog2(ROW_DEPTH + 1);
    localparam int LANE_AW   = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam int MEM_AW    = RAW + LANE_AW;
    localparam int MEM_DEPTH = ROW_DEPTH * (2 ** LANE_AW);

    localparam logic [RAW-1:0]    LAST_ROW = RAW'(ROW_DEPTH - 1);
    localparam logic [MEM_AW-1:0] LAST_ADR = MEM_AW'(MEM_DEPTH - 1);
    localparam logic [CW-1:0]     FULL_CNT = CW'(ROW_DEPTH);

    logic [31:0] mem [MEM_DEPTH];

    logic [RAW-1:0]    head_reg,  head_next;
    logic [RAW-1:0]    tail_reg,  tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MEM_AW-1:0] clr_adr_reg;

    logic [1:0]        s1_st_reg,    s1_st_next;
    logic [CW-1:0]     s1_count_reg;
    logic              s1_rd_ok_reg, s1_rd_ok_next;
    logic [31:0]       mem_q_reg;
    rsp_t              rsp_reg;

    logic              full, empty, lane_ok, pos_ok;
    logic [RAW-1:0]    tail_inc, tail_dec, head_inc, rd_row;
    logic [LANE_AW-1:0] lane_idx;
    logic              mem_we;
    logic [MEM_AW-1:0] waddr, raddr;
    logic [31:0]       wdata;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign lane_ok  = (32'(req_data.lane) < ROW_WIDTH);
    assign pos_ok   = (32'(req_data.position) < ROW_DEPTH);
    assign lane_idx = LANE_AW'(req_data.lane);
    assign tail_inc = (tail_reg == LAST_ROW) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_ROW : tail_reg - 1'b1;
    assign head_inc = (head_reg == LAST_ROW) ? '0 : head_reg + 1'b1;

    assign stat.clear_done = (clr_adr_reg == LAST_ADR);
    assign rsp_data        = rsp_reg;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        s1_st_next    = ST_OK;
        s1_rd_ok_next = 1'b0;
        rd_row        = head_reg;
        mem_we        = 1'b0;

        case (req_data.req_type)
            REQ_WRITE:
            begin
                if (full)
                begin
                    s1_st_next = ST_FULL;
                end
                else
                begin
                    mem_we = lane_ok;
                end
            end
            REQ_COMMIT:
            begin
                if (full)
                begin
                    s1_st_next = ST_FULL;
                end
                else
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REL_FIRST:
            begin
                if (empty)
                begin
                    s1_st_next = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_REL_LAST:
            begin
                if (empty)
                begin
                    s1_st_next = ST_EMPTY;
                end
                else
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_RD_FIRST:
            begin
                rd_row        = head_reg;
                s1_rd_ok_next = lane_ok;
            end
            REQ_RD_LAST:
            begin
                rd_row        = tail_dec;
                s1_rd_ok_next = lane_ok;
            end
            REQ_RD_AT:
            begin
                rd_row        = RAW'(req_data.position);
                s1_rd_ok_next = lane_ok && pos_ok;
            end
            default:
            begin
                s1_rd_ok_next = 1'b0;
            end
        endcase

        raddr = {rd_row, lane_idx};
        // zero the store after reset, then take element writes
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            waddr  = clr_adr_reg;
            wdata  = '0;
        end
        else
        begin
            mem_we = mem_we && cmd.accept;
            waddr  = {tail_reg, lane_idx};
            wdata  = req_data.write_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.accept)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            clr_adr_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step && !stat.clear_done)
            begin
                clr_adr_reg <= clr_adr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_st_reg    <= s1_st_next;
            s1_count_reg <= count_next;
            s1_rd_ok_reg <= s1_rd_ok_next;
        end
        if (cmd.advance)
        begin
            rsp_reg.read_value   <= s1_rd_ok_reg ? mem_q_reg : '0;
            rsp_reg.status       <= s1_st_reg;
            rsp_reg.stored_count <= 5'(s1_count_reg);
        end
    end

endmodule

// ===== src/row_ring_buffer_unit.sv =====
// Row ring buffer: a circular FIFO of ROW_DEPTH rows of ROW_WIDTH signed 32-bit
// elements. Each request beat (write tail element, commit row, release first,
// release last, read first/last/absolute row) returns exactly one response
// beat with the read value (zero unless a read), a status (ok, full rejected,
// empty rejected) and the row count after the request. After reset the element
// store is swept to zero one element per cycle, with req_stall held high. The
// sweep covers ROW_DEPTH times the lane count rounded up to a power of two, at
// least two lanes. After that one request is taken per cycle unless a stalled
// response has both stages full. The store read is registered at the accepting
// edge, and the result register loads from it when the result advances, which
// a stalled response can hold off; rsp_valid rises as the result register loads.
// The registered store read and one result register form the pipeline. A
// stalled response holds the next request in flight and stalls the request
// side only when both stages are full.
module row_ring_buffer_unit #(
    parameter int ROW_DEPTH = rrb_pkg::ROW_DEPTH_DEF,
    parameter int ROW_WIDTH = rrb_pkg::ROW_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rrb_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rrb_pkg::rsp_t rsp_data
);
    import rrb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence clear sweep, accept and result advance
    rrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // pointers, count, element store and result register
    rrb_datapath #(
        .ROW_DEPTH (ROW_DEPTH),
        .ROW_WIDTH (ROW_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

// ===== src/rrb_checker.sv =====
module rrb_checker #(
    parameter int ROW_DEPTH = rrb_pkg::ROW_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input rrb_pkg::rsp_t rsp_data
);
    import rrb_pkg::*;

    // hold a stalled response beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response beat changed");

    // take no request right after reset is released
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> req_stall)
        else $error("request accepted right after reset");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_FULL) |->
            (rsp_data.stored_count == 5'(ROW_DEPTH)))
        else $error("full rejection with buffer not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_EMPTY) |-> (rsp_data.stored_count == 5'd0))
        else $error("empty rejection with rows held");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (ROW_DEPTH > 31) || (32'(rsp_data.stored_count) <= ROW_DEPTH))
        else $error("row count beyond depth");

endmodule

bind row_ring_buffer_unit rrb_checker #(
    .ROW_DEPTH (ROW_DEPTH)
) u_rrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

// ===== bench/row_ring_buffer_checker.sv =====
module row_ring_buffer_checker #(
    parameter int ROW_DEPTH = rrb_pkg::ROW_DEPTH_DEF,
    parameter int ROW_WIDTH = rrb_pkg::ROW_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  rrb_pkg::req_t req_data,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  rrb_pkg::rsp_t rsp_data,
    output int            fail_count,
    output int            outstanding,
    output int            checked,
    output int            full_rejects,
    output int            empty_rejects
);
    import rrb_pkg::*;

    localparam int MAX_PRINTED = 40;

    // shadow copy of the ring: element store, pointers and row count
    logic [31:0] ring_rows [ROW_DEPTH][ROW_WIDTH];
    int          head_row;
    int          tail_row;
    int          rows_held;
    rsp_t        due_rsp_q [$];

    function automatic int next_row(input int r);
        return (r + 1 >= ROW_DEPTH) ? 0 : r + 1;
    endfunction

    function automatic int prev_row(input int r);
        return (r == 0) ? ROW_DEPTH - 1 : r - 1;
    endfunction

    function automatic logic [31:0] element_at(input int row, input int ln);
        if (row >= ROW_DEPTH || ln >= ROW_WIDTH)
        begin
            return '0;
        end
        return ring_rows[row][ln];
    endfunction

    // Advance the shadow ring by one request and return the response it owes.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   ln;
        int   pos;
        bit   full;
        bit   empty;
        o     = '0;
        ln    = r.lane;
        pos   = r.position;
        full  = rows_held >= ROW_DEPTH;
        empty = rows_held == 0;
        o.status = ST_OK;
        case (r.req_type)
            REQ_WRITE:
            begin
                if (full)
                begin
                    o.status = ST_FULL;
                end
                else if (ln < ROW_WIDTH)
                begin
                    ring_rows[tail_row][ln] = r.write_value;
                end
            end
            REQ_COMMIT:
            begin
                if (full)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    tail_row  = next_row(tail_row);
                    rows_held = rows_held + 1;
                end
            end
            REQ_REL_FIRST:
            begin
                if (empty)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    head_row  = next_row(head_row);
                    rows_held = rows_held - 1;
                end
            end
            REQ_REL_LAST:
            begin
                if (empty)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    tail_row  = prev_row(tail_row);
                    rows_held = rows_held - 1;
                end
            end
            REQ_RD_FIRST: o.read_value = element_at(head_row, ln);
            REQ_RD_LAST:  o.read_value = element_at(prev_row(tail_row), ln);
            REQ_RD_AT:    o.read_value = element_at(pos, ln);
            default:      ;
        endcase
        if (o.status == ST_FULL)
        begin
            full_rejects = full_rejects + 1;
        end
        if (o.status == ST_EMPTY)
        begin
            empty_rejects = empty_rejects + 1;
        end
        o.stored_count = 5'(rows_held);
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_PRINTED)
        begin
            $display("mismatch @%0t beat %0d: %s", $realtime, checked, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_DEPTH; r++)
            begin
                for (int e = 0; e < ROW_WIDTH; e++)
                begin
                    ring_rows[r][e] = '0;
                end
            end
            head_row  = 0;
            tail_row  = 0;
            rows_held = 0;
            due_rsp_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    report_mismatch("response beat with nothing expected");
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        report_mismatch($sformatf("read_value got %0d want %0d",
                                                  rsp_data.read_value, want.read_value));
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_data.status, want.status));
                    end
                    if (rsp_data.stored_count !== want.stored_count)
                    begin
                        report_mismatch($sformatf("stored_count got %0d want %0d",
                                                  rsp_data.stored_count, want.stored_count));
                    end
                    checked = checked + 1;
                end
            end
            if (req_valid && !req_stall)
            begin
                due_rsp_q.push_back(apply_request(req_data));
            end
            outstanding <= due_rsp_q.size();
        end
    end

endmodule

// ===== bench/row_ring_buffer_unit_tb.sv =====
module row_ring_buffer_unit_tb;
    import rrb_pkg::*;

    localparam int ROW_DEPTH = ROW_DEPTH_DEF;
    localparam int ROW_WIDTH = ROW_WIDTH_DEF;

    // Settle margin after the last drain: the response latency with slack on top.
    localparam int RSP_LATENCY   = 2;
    localparam int SETTLE_CYCLES = RSP_LATENCY + 6;
    localparam int HOLD_CYCLES   = 90;
    localparam int HOLD_BEATS    = 30;
    localparam int BEATS_PER_MIX = 250;
    localparam int SEGMENT_BEATS = 70;
    localparam int DRAIN_LIMIT   = 20000;

    // Request code the block leaves unused; it must change nothing.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Op mixes for the random part: grow the ring, keep it level, shrink it.
    localparam int MIX_FILL  = 0;
    localparam int MIX_EVEN  = 1;
    localparam int MIX_DRAIN = 2;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data  = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp_data;

    int    gap_pct    = 0;
    int    stall_pct  = 0;
    logic  long_hold  = 1'b0;
    int    beats_sent = 0;

    int    fail_count;
    int    outstanding;
    int    checked;
    int    full_rejects;
    int    empty_rejects;

    always #4 clk = ~clk;

    row_ring_buffer_unit #(
        .ROW_DEPTH (ROW_DEPTH),
        .ROW_WIDTH (ROW_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    row_ring_buffer_checker #(
        .ROW_DEPTH (ROW_DEPTH),
        .ROW_WIDTH (ROW_WIDTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked       (checked),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    // Receiver: stall at random at the current rate, and hold solid while a
    // long hold-off is running.
    always @(posedge clk)
    begin
        rsp_stall <= long_hold || (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    function automatic req_t make_req(input logic [2:0] op, input logic [1:0] ln,
                                      input logic [3:0] pos, input logic [31:0] val);
        req_t r;
        r.req_type    = op;
        r.lane        = ln;
        r.position    = pos;
        r.write_value = val;
        return r;
    endfunction

    // Draw one request beat. The mix sets how often rows are committed versus
    // released, so that fill segments run the ring into full and drain
    // segments run it dry. Every field gets random content whatever the op.
    function automatic req_t random_request(input int mix);
        logic [2:0] ops [8];
        int         cuts [8];
        int         roll;
        req_t       r;
        ops  = '{REQ_WRITE, REQ_COMMIT, REQ_REL_FIRST, REQ_REL_LAST,
                 REQ_RD_FIRST, REQ_RD_LAST, REQ_RD_AT, REQ_UNUSED};
        case (mix)
            MIX_FILL:  cuts = '{30, 65, 69, 71, 79, 87, 98, 100};
            MIX_DRAIN: cuts = '{15, 22, 45, 62, 72, 82, 98, 100};
            default:   cuts = '{25, 45, 55, 65, 75, 85, 98, 100};
        endcase
        roll = $urandom_range(99);
        r    = make_req(ops[7], 2'($urandom), 4'($urandom), $urandom);
        for (int i = 7; i >= 0; i--)
        begin
            if (roll < cuts[i])
            begin
                r.req_type = ops[i];
            end
        end
        return r;
    endfunction

    // Offer one beat and hold it until the block takes it, then idle the
    // request side at random at the current gap rate.
    task automatic send_beat(input req_t beat);
        req_valid <= 1'b1;
        req_data  <= beat;
        do @(posedge clk); while (req_stall !== 1'b0);
        beats_sent++;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop valid and wait for every owed response, up to a cycle limit.
    task automatic pause_until_drained();
        int waited;
        waited    = 0;
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
    endtask

    // One idle/stall mix: cycle through fill, level and drain segments.
    task automatic run_mix(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct <= stall;
        for (int k = 0; k < BEATS_PER_MIX; k++)
        begin
            case ((k / SEGMENT_BEATS) % 3)
                0:       send_beat(random_request(MIX_FILL));
                1:       send_beat(random_request(MIX_EVEN));
                default: send_beat(random_request(MIX_DRAIN));
            endcase
        end
    endtask

    // Hold the response side off for a long stretch while requests keep
    // coming, so both stages fill and the block stalls its input.
    task automatic hold_off_receiver();
        gap_pct   = 0;
        stall_pct <= 0;
        fork
            begin
                long_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        for (int k = 0; k < HOLD_BEATS; k++)
        begin
            send_beat(random_request(MIX_EVEN));
        end
        pause_until_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. The block sweeps its store after reset
        // with req_stall high; the first beat simply waits that out.
        // Reads on an empty ring, incl. the last row wrapping to the top row.
        send_beat(make_req(REQ_RD_FIRST, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_LAST, 2'd3, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_AT, 2'd3, 4'd15, 32'h0));
        // Releases on an empty ring are rejected.
        send_beat(make_req(REQ_REL_FIRST, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_REL_LAST, 2'd0, 4'd0, 32'h0));
        // Unused code with all fields at their top.
        send_beat(make_req(REQ_UNUSED, 2'd3, 4'd15, 32'hffff_ffff));
        // Fill row 0 with the value extremes and commit it.
        send_beat(make_req(REQ_WRITE, 2'd0, 4'd0, 32'h7fff_ffff));
        send_beat(make_req(REQ_WRITE, 2'd1, 4'd9, 32'h8000_0000));
        send_beat(make_req(REQ_WRITE, 2'd2, 4'd0, 32'h0000_0000));
        send_beat(make_req(REQ_WRITE, 2'd3, 4'd6, 32'hffff_ffff));
        send_beat(make_req(REQ_COMMIT, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_FIRST, 2'd1, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_LAST, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_AT, 2'd3, 4'd0, 32'h0));
        // Second row, then take it back off the end.
        send_beat(make_req(REQ_WRITE, 2'd2, 4'd0, 32'h5a5a_a5a5));
        send_beat(make_req(REQ_COMMIT, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_REL_LAST, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_LAST, 2'd2, 4'd0, 32'h0));
        // Release the front row; head and tail now both sit on row 1.
        send_beat(make_req(REQ_REL_FIRST, 2'd0, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_FIRST, 2'd2, 4'd0, 32'h0));
        send_beat(make_req(REQ_RD_AT, 2'd2, 4'd1, 32'h0));

        // Random part across the idle/stall mixes, with a long hold-off and
        // a full drain in between.
        run_mix(0, 0);
        run_mix(66, 0);
        hold_off_receiver();
        run_mix(0, 66);
        run_mix(34, 34);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d request beats under four idle/stall mixes plus a long hold-off",
                 beats_sent);
        $display("run: %0d responses compared, %0d full and %0d empty rejections seen",
                 checked, full_rejects, empty_rejects);
        if (outstanding != 0)
        begin
            $display("responses still owed at end: %0d", outstanding);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: a correct run needs a small fraction of this.
    initial
    begin
        #2_000_000;
        $display("timeout: run did not complete");
        $display("status: fail");
        $finish;
    end

endmodule
